// ----- rtl/core/i2cmbe_pkg.sv -----
// Package for the I2C master bit engine: phase codes, opcodes, sizes and the
// engine state and result records. No dependencies.
package i2cmbe_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned CountW = 4;
  localparam int unsigned PollW = 8;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [PollW-1:0] AckPollLimitRst = PollW'(100);

  localparam logic [2:0] OpNone = 3'd0;
  localparam logic [2:0] OpStart = 3'd1;
  localparam logic [2:0] OpStop = 3'd2;
  localparam logic [2:0] OpWrite = 3'd3;
  localparam logic [2:0] OpRead = 3'd4;
  localparam logic [2:0] OpWait = 3'd5;
  localparam logic [2:0] OpAck = 3'd6;
  localparam logic [2:0] OpNack = 3'd7;

  localparam logic [PhaseW-1:0] PhIdle = 4'd0;
  localparam logic [PhaseW-1:0] PhStart = 4'd1;
  localparam logic [PhaseW-1:0] PhStop = 4'd2;
  localparam logic [PhaseW-1:0] PhWrite = 4'd3;
  localparam logic [PhaseW-1:0] PhRead = 4'd4;
  localparam logic [PhaseW-1:0] PhWait = 4'd5;
  localparam logic [PhaseW-1:0] PhAck = 4'd6;
  localparam logic [PhaseW-1:0] PhNack = 4'd7;
  localparam logic [PhaseW-1:0] PhRdAck = 4'd8;
  localparam logic [PhaseW-1:0] PhToStop = 4'd9;

  typedef struct packed {
    logic [PhaseW-1:0]   phase;
    logic [CountW-1:0]   bit_count;
    logic [ByteBits-1:0] shift_reg;
    logic [PollW-1:0]    poll_count;
    logic                pending_ack;
    logic                line_scl;
    logic                line_sda;
    logic                fail_flag;
    logic [ByteBits-1:0] rx_hold;
  } eng_state_t;

  typedef struct packed {
    logic                ack_failed;
    logic [ByteBits-1:0] rx_byte;
    logic                done_res;
    logic                busy_res;
    logic                sda_out;
    logic                scl_out;
  } eng_result_t;

endpackage

// ----- rtl/core/i2c_master_bit_engine_core.sv -----
// I2C master bit engine, top level: tick stream in, line levels out.
// Depends on i2cmbe_pkg and i2cmbe_step.
// Each input word is one bus tick and yields one registered output word, valid in the cycle after it is accepted.
// Throughput is one word per cycle while the output is not stalled; the output register frees as its word leaves.
// Reset puts the engine idle with both lines high and the poll limit at 100.
module i2c_master_bit_engine_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [i2cmbe_pkg::PollW-1:0]         cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // opcode[2:0], tx_byte[10:3], ack_after_read[11], sda_in[12], zero[15:13]
  input  logic [i2cmbe_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
  // ack_failed[12], zero[15:13]
  output logic [i2cmbe_pkg::OutDataW-1:0]      m_axis_tdata
);
  import i2cmbe_pkg::*;

  localparam eng_state_t StateRst = '{
    phase: PhIdle, bit_count: '0, shift_reg: '0, poll_count: '0,
    pending_ack: 1'b0, line_scl: 1'b1, line_sda: 1'b1, fail_flag: 1'b0,
    rx_hold: '0
  };

  eng_state_t       state_q;
  eng_state_t       state_d;
  eng_result_t      result_d;
  eng_result_t      result_q;
  logic             out_valid_q;
  logic [PollW-1:0] limit_q;
  logic             in_accept;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_accept = s_axis_tvalid & s_axis_tready;

  i2cmbe_step u_step (
    .state_i          (state_q),
    .opcode_i         (s_axis_tdata[2:0]),
    .tx_byte_i        (s_axis_tdata[10:3]),
    .ack_after_read_i (s_axis_tdata[11]),
    .sda_in_i         (s_axis_tdata[12]),
    .ack_poll_limit_i (limit_q),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
      out_valid_q <= 1'b0;
      limit_q <= AckPollLimitRst;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        state_q <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {3'b000, result_q};

endmodule

// ----- rtl/core/i2cmbe_step.sv -----
// Next-state and per-tick result logic of the I2C master bit engine.
// Depends on i2cmbe_pkg.
module i2cmbe_step (
  input  i2cmbe_pkg::eng_state_t         state_i,
  input  logic [2:0]                      opcode_i,
  input  logic [i2cmbe_pkg::ByteBits-1:0] tx_byte_i,
  input  logic                            ack_after_read_i,
  input  logic                            sda_in_i,
  input  logic [i2cmbe_pkg::PollW-1:0]    ack_poll_limit_i,
  output i2cmbe_pkg::eng_state_t         state_o,
  output i2cmbe_pkg::eng_result_t        result_o
);
  import i2cmbe_pkg::*;

  eng_state_t           s;
  logic                 oc;
  logic                 od;
  logic                 busy;
  logic                 done;
  logic                 bit_val;
  logic [2:0]           pos;
  logic [PollW:0]       poll_inc;

  always_comb begin
    s = state_i;
    busy = 1'b1;
    done = 1'b0;
    bit_val = 1'b1;
    pos = 3'(ByteBits - 1) - s.bit_count[3:1];
    poll_inc = {1'b0, s.poll_count} + (PollW+1)'(1);

    if (s.phase == PhIdle) begin
      if (opcode_i == OpNone) begin
        busy = 1'b0;
      end else begin
        s.phase = {1'b0, opcode_i};
        s.bit_count = '0;
        s.poll_count = '0;
        if (opcode_i == OpWrite) begin
          s.shift_reg = tx_byte_i;
        end
        if (opcode_i == OpRead) begin
          s.shift_reg = '0;
          s.pending_ack = ack_after_read_i;
        end
      end
    end

    pos = 3'(ByteBits - 1) - s.bit_count[3:1];
    poll_inc = {1'b0, s.poll_count} + (PollW+1)'(1);
    oc = s.line_scl;
    od = s.line_sda;

    case (s.phase)
      PhStart: begin
        s.line_scl = 1'b1;
        oc = 1'b1;
        if (s.bit_count == '0) begin
          s.line_sda = 1'b1;
          s.bit_count = CountW'(1);
          od = 1'b1;
        end else begin
          s.line_sda = 1'b0;
          od = 1'b0;
          s.line_scl = 1'b0;
          done = 1'b1;
        end
      end
      PhStop, PhToStop: begin
        s.line_scl = 1'b1;
        oc = 1'b1;
        if (s.bit_count == '0) begin
          s.line_sda = 1'b0;
          s.bit_count = CountW'(1);
          od = 1'b0;
        end else begin
          s.line_sda = 1'b1;
          od = 1'b1;
          if (s.phase == PhToStop) begin
            s.fail_flag = 1'b1;
          end
          done = 1'b1;
        end
      end
      PhAck, PhNack, PhRdAck: begin
        if (s.phase == PhAck) begin
          bit_val = 1'b0;
        end else if (s.phase == PhNack) begin
          bit_val = 1'b1;
        end else begin
          bit_val = ~s.pending_ack;
        end
        s.line_sda = bit_val;
        od = bit_val;
        if (s.bit_count == '0) begin
          s.line_scl = 1'b0;
          s.bit_count = CountW'(1);
          oc = 1'b0;
        end else begin
          oc = 1'b1;
          s.line_scl = 1'b0;
          done = 1'b1;
        end
      end
      PhWrite: begin
        s.line_sda = s.shift_reg[pos];
        s.line_scl = ~s.bit_count[0];
        oc = s.line_scl;
        od = s.line_sda;
        if (s.bit_count == CountW'(2 * ByteBits - 1)) begin
          s.line_scl = 1'b0;
          done = 1'b1;
        end else begin
          s.bit_count = s.bit_count + CountW'(1);
        end
      end
      PhRead: begin
        s.line_sda = 1'b1;
        s.line_scl = s.bit_count[0];
        oc = s.line_scl;
        od = 1'b1;
        if (s.bit_count[0]) begin
          s.shift_reg = {s.shift_reg[ByteBits-2:0], sda_in_i};
        end
        if (s.bit_count == CountW'(2 * ByteBits - 1)) begin
          s.rx_hold = s.shift_reg;
          s.phase = PhRdAck;
          s.bit_count = '0;
        end else begin
          s.bit_count = s.bit_count + CountW'(1);
        end
      end
      PhWait: begin
        s.line_scl = 1'b1;
        oc = 1'b1;
        od = s.line_sda;
        if (!sda_in_i) begin
          s.line_scl = 1'b0;
          s.fail_flag = 1'b0;
          done = 1'b1;
        end else if (poll_inc > {1'b0, ack_poll_limit_i}) begin
          s.phase = PhToStop;
          s.bit_count = '0;
        end else begin
          s.poll_count = poll_inc[PollW-1:0];
        end
      end
      default: begin
      end
    endcase

    if (done) begin
      s.phase = PhIdle;
      s.bit_count = '0;
    end

    state_o = s;
    result_o.scl_out = oc;
    result_o.sda_out = od;
    result_o.busy_res = busy;
    result_o.done_res = done;
    result_o.rx_byte = s.rx_hold;
    result_o.ack_failed = s.fail_flag;
  end

endmodule

// ----- tb/i2c_master_bit_engine_core_checker.sv -----
`timescale 1ns / 100ps
// Checker for the I2C master bit engine: predicts the line levels and status of every
// tick word and compares them with the output words. Depends on i2cmbe_pkg.
module i2c_master_bit_engine_core_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [i2cmbe_pkg::PollW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [i2cmbe_pkg::InDataW-1:0]  in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [i2cmbe_pkg::OutDataW-1:0] out_data_i,
  output int                              pending_o,
  output int                              errors_o
);
  import i2cmbe_pkg::*;

  eng_state_t       eng_st;
  logic [PollW-1:0] poll_limit;
  eng_result_t      line_results_q[$];
  int               err_count;

  task automatic reset_engine();
    eng_st = '0;
    eng_st.phase = PhIdle;
    eng_st.line_scl = 1'b1;
    eng_st.line_sda = 1'b1;
    poll_limit = AckPollLimitRst;
  endtask

  task automatic advance_bus_tick(input logic [2:0] op, input logic [ByteBits-1:0] tx,
                                  input logic ack_rd, input logic sda,
                                  output eng_result_t res);
    logic busy;
    logic done;
    logic v;
    logic [2:0] pos;
    busy = 1'b1;
    done = 1'b0;
    if (eng_st.phase == PhIdle) begin
      if (op == OpNone) begin
        busy = 1'b0;
      end else begin
        eng_st.phase = PhaseW'(op);
        eng_st.bit_count = '0;
        eng_st.poll_count = '0;
        if (op == OpWrite) eng_st.shift_reg = tx;
        if (op == OpRead) begin
          eng_st.shift_reg = '0;
          eng_st.pending_ack = ack_rd;
        end
      end
    end
    res = '0;
    res.scl_out = eng_st.line_scl;
    res.sda_out = eng_st.line_sda;
    case (eng_st.phase)
      PhStart: begin
        eng_st.line_scl = 1'b1;
        res.scl_out = 1'b1;
        if (eng_st.bit_count == 0) begin
          eng_st.line_sda = 1'b1;
          eng_st.bit_count = CountW'(1);
          res.sda_out = 1'b1;
        end else begin
          eng_st.line_sda = 1'b0;
          eng_st.line_scl = 1'b0;
          res.sda_out = 1'b0;
          done = 1'b1;
        end
      end
      PhStop, PhToStop: begin
        eng_st.line_scl = 1'b1;
        res.scl_out = 1'b1;
        if (eng_st.bit_count == 0) begin
          eng_st.line_sda = 1'b0;
          eng_st.bit_count = CountW'(1);
          res.sda_out = 1'b0;
        end else begin
          eng_st.line_sda = 1'b1;
          res.sda_out = 1'b1;
          if (eng_st.phase == PhToStop) eng_st.fail_flag = 1'b1;
          done = 1'b1;
        end
      end
      PhAck, PhNack, PhRdAck: begin
        if (eng_st.phase == PhAck) v = 1'b0;
        else if (eng_st.phase == PhNack) v = 1'b1;
        else v = ~eng_st.pending_ack;
        eng_st.line_sda = v;
        res.sda_out = v;
        if (eng_st.bit_count == 0) begin
          eng_st.line_scl = 1'b0;
          eng_st.bit_count = CountW'(1);
          res.scl_out = 1'b0;
        end else begin
          res.scl_out = 1'b1;
          eng_st.line_scl = 1'b0;
          done = 1'b1;
        end
      end
      PhWrite: begin
        pos = ~eng_st.bit_count[3:1];
        v = eng_st.shift_reg[pos];
        eng_st.line_sda = v;
        eng_st.line_scl = ~eng_st.bit_count[0];
        res.scl_out = eng_st.line_scl;
        res.sda_out = v;
        if (eng_st.bit_count >= 2 * ByteBits - 1) begin
          eng_st.line_scl = 1'b0;
          done = 1'b1;
        end else begin
          eng_st.bit_count = eng_st.bit_count + CountW'(1);
        end
      end
      PhRead: begin
        eng_st.line_sda = 1'b1;
        eng_st.line_scl = eng_st.bit_count[0];
        res.scl_out = eng_st.line_scl;
        res.sda_out = 1'b1;
        if (eng_st.bit_count[0]) eng_st.shift_reg = {eng_st.shift_reg[ByteBits-2:0], sda};
        if (eng_st.bit_count >= 2 * ByteBits - 1) begin
          eng_st.rx_hold = eng_st.shift_reg;
          eng_st.phase = PhRdAck;
          eng_st.bit_count = '0;
        end else begin
          eng_st.bit_count = eng_st.bit_count + CountW'(1);
        end
      end
      PhWait: begin
        eng_st.line_scl = 1'b1;
        res.scl_out = 1'b1;
        res.sda_out = eng_st.line_sda;
        if (!sda) begin
          eng_st.line_scl = 1'b0;
          eng_st.fail_flag = 1'b0;
          done = 1'b1;
        end else if ({1'b0, eng_st.poll_count} + 9'd1 > {1'b0, poll_limit}) begin
          eng_st.phase = PhToStop;
          eng_st.bit_count = '0;
        end else begin
          eng_st.poll_count = eng_st.poll_count + PollW'(1);
        end
      end
      default: begin
      end
    endcase
    if (done) begin
      eng_st.phase = PhIdle;
      eng_st.bit_count = '0;
    end
    res.busy_res = busy;
    res.done_res = done;
    res.rx_byte = eng_st.rx_hold;
    res.ack_failed = eng_st.fail_flag;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    eng_result_t got;
    eng_result_t want;
    eng_result_t res;
    if (!rst_ni) begin
      reset_engine();
      line_results_q.delete();
      err_count = 0;
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = eng_result_t'(out_data_i[$bits(eng_result_t)-1:0]);
        if (line_results_q.size() == 0) begin
          $error("output word %0h arrived with no word expected", out_data_i);
          err_count++;
        end else begin
          want = line_results_q.pop_front();
          compare_field("scl_out", want.scl_out, got.scl_out);
          compare_field("sda_out", want.sda_out, got.sda_out);
          compare_field("busy_res", want.busy_res, got.busy_res);
          compare_field("done_res", want.done_res, got.done_res);
          compare_field("rx_byte", want.rx_byte, got.rx_byte);
          compare_field("ack_failed", want.ack_failed, got.ack_failed);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_bus_tick(in_data_i[2:0], in_data_i[10:3], in_data_i[11], in_data_i[12], res);
        line_results_q.push_back(res);
      end
      if (cfg_we_i) poll_limit = cfg_wdata_i;
      pending_o <= line_results_q.size();
      errors_o <= err_count;
    end
  end

endmodule

// ----- tb/i2c_master_bit_engine_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the I2C master bit engine: drives command and tick words with
// random gaps and stalls, and gives the verdict. Depends on i2cmbe_pkg, the core and the checker.
module i2c_master_bit_engine_core_tb;
  import i2cmbe_pkg::*;

  localparam int SdaLow = 0;
  localparam int SdaHigh = 1;
  localparam int SdaRand = 2;
  localparam int WatchdogLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [PollW-1:0]    cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  int                  pending;
  int                  errors;

  logic [PollW-1:0] poll_limit_now = AckPollLimitRst;
  int               burst_left = 0;
  int               ticks_sent = 0;
  int               sda_fill = SdaRand;
  int               idle_cycles = 0;
  logic [1:0]       stall_mode = 2'd0;
  logic [5:0]       stall_step = '0;

  always #5 clk_i = ~clk_i;

  i2c_master_bit_engine_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  i2c_master_bit_engine_core_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always @(posedge clk_i) begin
    stall_step <= stall_step + 6'd1;
    case (stall_mode)
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 3) != 0);
      2'd2: m_tready <= (stall_step[1:0] == 2'd0);
      default: m_tready <= ($urandom_range(0, 1) == 1);
    endcase
    if (stall_step == '0) stall_mode <= 2'($urandom_range(0, 3));
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("i2c_master_bit_engine_core: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic fill_sda();
    if (sda_fill == SdaLow) return 1'b0;
    if (sda_fill == SdaHigh) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic drive_tick(input logic [2:0] op, input logic [ByteBits-1:0] tx,
                            input logic ack_rd, input logic sda);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, sda, ack_rd, tx, op};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
    ticks_sent++;
  endtask

  // A command word followed by the ticks that carry it to completion. Words sent
  // while the engine is known to be busy sometimes carry an opcode, which it ignores.
  task automatic issue_command(input logic [2:0] op, input logic [ByteBits-1:0] tx,
                               input logic ack_rd, input int hi_polls);
    int len;
    logic [2:0] fop;
    logic sda;
    case (op)
      OpNone: len = 1;
      OpWrite: len = 2 * ByteBits;
      OpRead: len = 2 * ByteBits + 2;
      OpWait: len = (hi_polls <= poll_limit_now) ? hi_polls + 1 : poll_limit_now + 3;
      default: len = 2;
    endcase
    for (int j = 0; j < len; j++) begin
      if (j == 0) fop = op;
      else if ($urandom_range(0, 5) == 0) fop = 3'($urandom_range(0, 7));
      else fop = OpNone;
      if (op != OpWait) sda = fill_sda();
      else if (j < hi_polls) sda = 1'b1;
      else if (j == hi_polls) sda = 1'b0;
      else sda = 1'($urandom_range(0, 1));
      drive_tick(fop, (j == 0) ? tx : 8'($urandom_range(0, 255)),
                 (j == 0) ? ack_rd : 1'($urandom_range(0, 1)), sda);
    end
  endtask

  task automatic set_poll_limit(input logic [PollW-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    poll_limit_now = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase_end;
    int pick;
    int k;
    logic [2:0] op;
    logic [PollW-1:0] lim;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_command(OpNone, 8'h00, 1'b0, 0);
    issue_command(OpStart, 8'hFF, 1'b1, 0);
    issue_command(OpWrite, 8'h00, 1'b0, 0);
    issue_command(OpWrite, 8'hFF, 1'b1, 0);
    issue_command(OpWrite, 8'hA5, 1'b0, 0);
    issue_command(OpWait, 8'h00, 1'b0, 0);
    issue_command(OpWait, 8'h00, 1'b0, 3);
    issue_command(OpWait, 8'h00, 1'b0, int'(poll_limit_now) + 1);
    sda_fill = SdaHigh;
    issue_command(OpRead, 8'h00, 1'b1, 0);
    sda_fill = SdaLow;
    issue_command(OpRead, 8'h00, 1'b0, 0);
    sda_fill = SdaRand;
    issue_command(OpAck, 8'h00, 1'b0, 0);
    issue_command(OpNack, 8'h00, 1'b0, 0);
    issue_command(OpStop, 8'h00, 1'b0, 0);
    issue_command(OpNone, 8'h00, 1'b0, 0);
    set_poll_limit(8'd0);
    issue_command(OpWait, 8'h00, 1'b0, 1);
    issue_command(OpWait, 8'h00, 1'b0, 0);
    issue_command(OpWait, 8'h00, 1'b0, 2);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: lim = 8'd255;
        1: lim = 8'd1;
        2: lim = 8'd0;
        3: lim = 8'($urandom_range(2, 40));
        default: lim = 8'($urandom_range(0, 255));
      endcase
      set_poll_limit(lim);
      phase_end = ticks_sent + 150;
      while (ticks_sent < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 5) op = OpWrite;
        else if (pick < 9) op = OpRead;
        else if (pick < 13) op = OpWait;
        else if (pick < 15) op = OpNone;
        else op = 3'($urandom_range(1, 7));
        case ($urandom_range(0, 2))
          0: k = $urandom_range(0, 3);
          1: k = int'(poll_limit_now) + $urandom_range(0, 2) - 1;
          default: k = $urandom_range(0, int'(poll_limit_now) + 2);
        endcase
        if (k < 0) k = 0;
        case ($urandom_range(0, 5))
          0: sda_fill = SdaLow;
          1: sda_fill = SdaHigh;
          default: sda_fill = SdaRand;
        endcase
        issue_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), k);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("i2c_master_bit_engine_core: match");
    end else begin
      $display("i2c_master_bit_engine_core: mismatch");
    end
    $finish;
  end

endmodule
